// ===== rtl/cghp_pkg.sv =====
// ----------------------------------------------------------------------------
// cghp_pkg: shared types and constants of the CGI header field parser
// Result codes, parser phases, byte constants and the header name tables.
// ----------------------------------------------------------------------------
package cghp_pkg;

  typedef enum logic [3:0] {
    KIND_NAME     = 4'd0,
    KIND_VALUE    = 4'd1,
    KIND_IGNORED  = 4'd2,
    KIND_FIELD_END = 4'd3,
    KIND_REDIRECT = 4'd4,
    KIND_BODY_END = 4'd5,
    KIND_STATUS_ONLY = 4'd6,
    KIND_MALFORMED = 4'd7,
    KIND_MISSING  = 4'd8,
    KIND_CGI_ERROR = 4'd9,
    KIND_BODY     = 4'd10,
    KIND_DROPPED  = 4'd11
  } kind_t;

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_NAME  = 6'b000010,
    PH_WS    = 6'b000100,
    PH_VALUE = 6'b001000,
    PH_CR    = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  localparam int CODE_W = 14;
  localparam int POS_W  = 4;
  localparam int CAND_N = 3;

  localparam logic [CODE_W-1:0] CODE_MAX     = 14'd9999;
  localparam logic [CODE_W-1:0] ERR_LIMIT    = 14'd400;
  localparam logic [CODE_W-1:0] INTERNAL_ERR = 14'd500;
  localparam logic [POS_W-1:0]  POS_MAX      = 4'd15;

  localparam logic [POS_W-1:0] LEN_STATUS   = 4'd6;
  localparam logic [POS_W-1:0] LEN_LOCATION = 4'd8;
  localparam logic [POS_W-1:0] LEN_CTYPE    = 4'd12;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        byte_out;
    logic [CODE_W-1:0] status_code;
    logic              status_present;
  } cghp_result_t;

  function automatic logic [7:0] status_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "S";
      4'd1:    c = "t";
      4'd2:    c = "a";
      4'd3:    c = "t";
      4'd4:    c = "u";
      4'd5:    c = "s";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] location_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "L";
      4'd1:    c = "o";
      4'd2:    c = "c";
      4'd3:    c = "a";
      4'd4:    c = "t";
      4'd5:    c = "i";
      4'd6:    c = "o";
      4'd7:    c = "n";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ctype_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "T";
      4'd9:    c = "y";
      4'd10:   c = "p";
      4'd11:   c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/cghp_name_match.sv =====
// ----------------------------------------------------------------------------
// cghp_name_match: header name candidate matcher
// Advances the per-candidate match flags by one name byte and gives the
// full-length mask used when the name closes at its colon.
// ----------------------------------------------------------------------------
module cghp_name_match
  import cghp_pkg::*;
(
  input  logic [CAND_N-1:0] alive,
  input  logic [POS_W-1:0]  pos,
  input  logic [7:0]        data_byte,
  output logic [CAND_N-1:0] alive_step,
  output logic [CAND_N-1:0] full_mask
);

  assign alive_step[0] = alive[0] && (pos < LEN_STATUS) && (status_char(pos) == data_byte);
  assign alive_step[1] = alive[1] && (pos < LEN_LOCATION) &&
                         (location_char(pos) == data_byte);
  assign alive_step[2] = alive[2] && (pos < LEN_CTYPE) && (ctype_char(pos) == data_byte);

  assign full_mask[0] = (pos == LEN_STATUS);
  assign full_mask[1] = (pos == LEN_LOCATION);
  assign full_mask[2] = (pos == LEN_CTYPE);

endmodule

// ===== rtl/cghp_core.sv =====
// ----------------------------------------------------------------------------
// cghp_core: parser state and per-byte step
// Holds the parser state, applies one byte per step and forms its result.
// ----------------------------------------------------------------------------
module cghp_core
  import cghp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         new_response,
  output cghp_result_t result
);

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  name_pos, name_pos_next;
  logic [CAND_N-1:0] alive, alive_next;
  logic [CODE_W-1:0] acc, acc_next;
  logic [CODE_W-1:0] status_value, status_value_next;
  logic [CAND_N-1:0] seen, seen_next;
  logic              body_enabled, body_enabled_next;

  phase_t            c_phase;
  logic [POS_W-1:0]  c_pos;
  logic [CAND_N-1:0] c_alive;
  logic [CODE_W-1:0] c_acc;
  logic [CODE_W-1:0] c_status;
  logic [CAND_N-1:0] c_seen;
  logic              c_body;

  logic [CAND_N-1:0] alive_step, full_mask;
  logic [16:0]       acc_sum;
  logic              is_digit;
  logic              do_name, do_value, do_end;
  kind_t             kind;

  assign c_phase  = new_response ? PH_START : phase;
  assign c_pos    = new_response ? '0 : name_pos;
  assign c_alive  = new_response ? '1 : alive;
  assign c_acc    = new_response ? '0 : acc;
  assign c_status = new_response ? '0 : status_value;
  assign c_seen   = new_response ? '0 : seen;
  assign c_body   = new_response ? 1'b0 : body_enabled;

  cghp_name_match u_name_match (
    .alive      (c_alive),
    .pos        (c_pos),
    .data_byte  (data_byte),
    .alive_step (alive_step),
    .full_mask  (full_mask)
  );

  assign acc_sum = ({3'b000, c_acc} << 3) + ({3'b000, c_acc} << 1) +
                   {13'd0, data_byte[3:0]};
  assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);

  always_comb begin
    phase_next        = c_phase;
    name_pos_next     = c_pos;
    alive_next        = c_alive;
    acc_next          = c_acc;
    status_value_next = c_status;
    seen_next         = c_seen;
    body_enabled_next = c_body;
    kind              = KIND_DROPPED;
    do_name           = 1'b0;
    do_value          = 1'b0;
    do_end            = 1'b0;

    unique case (c_phase)
      PH_START: begin
        if (data_byte == CHAR_CR) begin
          phase_next = PH_CR;
          kind       = KIND_IGNORED;
        end else if (data_byte == CHAR_LF) begin
          do_end = 1'b1;
        end else begin
          do_name = 1'b1;
        end
      end
      PH_NAME: do_name = 1'b1;
      PH_WS: begin
        if (data_byte == CHAR_SPACE) begin
          kind = KIND_IGNORED;
        end else begin
          do_value = 1'b1;
        end
      end
      PH_VALUE: do_value = 1'b1;
      PH_CR: begin
        if (data_byte == CHAR_LF) begin
          do_end = 1'b1;
        end else begin
          phase_next        = PH_DONE;
          body_enabled_next = 1'b0;
          status_value_next = INTERNAL_ERR;
          kind              = KIND_MALFORMED;
        end
      end
      default: kind = c_body ? KIND_BODY : KIND_DROPPED;
    endcase

    if (do_name) begin
      if (data_byte == CHAR_COLON) begin
        alive_next = c_alive & full_mask;
        acc_next   = '0;
        phase_next = PH_WS;
        kind       = KIND_IGNORED;
      end else begin
        alive_next = alive_step;
        if (c_pos != POS_MAX) begin
          name_pos_next = c_pos + 4'd1;
        end
        phase_next = PH_NAME;
        kind       = KIND_NAME;
      end
    end

    if (do_value) begin
      phase_next = PH_VALUE;
      if (data_byte == CHAR_CR) begin
        kind = KIND_IGNORED;
      end else if (data_byte != CHAR_LF) begin
        if (c_alive[0] && is_digit) begin
          acc_next = (acc_sum > {3'b000, CODE_MAX}) ? CODE_MAX : acc_sum[CODE_W-1:0];
        end
        kind = KIND_VALUE;
      end else begin
        seen_next  = c_seen | c_alive;
        kind       = KIND_FIELD_END;
        phase_next = PH_START;
        if (c_alive[0]) begin
          status_value_next = c_acc;
          if (c_acc >= ERR_LIMIT) begin
            phase_next        = PH_DONE;
            body_enabled_next = 1'b0;
            kind              = KIND_CGI_ERROR;
          end
        end
        name_pos_next = '0;
        alive_next    = '1;
        acc_next      = '0;
      end
    end

    if (do_end) begin
      phase_next        = PH_DONE;
      body_enabled_next = 1'b0;
      if (c_seen[1]) begin
        kind = KIND_REDIRECT;
      end else if (c_seen[2]) begin
        body_enabled_next = 1'b1;
        kind              = KIND_BODY_END;
      end else if (c_seen[0]) begin
        kind = KIND_STATUS_ONLY;
      end else begin
        status_value_next = INTERNAL_ERR;
        kind              = KIND_MISSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      name_pos     <= '0;
      alive        <= '1;
      acc          <= '0;
      status_value <= '0;
      seen         <= '0;
      body_enabled <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      name_pos     <= name_pos_next;
      alive        <= alive_next;
      acc          <= acc_next;
      status_value <= status_value_next;
      seen         <= seen_next;
      body_enabled <= body_enabled_next;
    end
  end

  assign result.kind           = kind;
  assign result.byte_out       = data_byte;
  assign result.status_code    = status_value_next;
  assign result.status_present = seen_next[0];

  a_reset_start: assert property (@(posedge clk) rst |=> phase == PH_START)
    else $error("phase not at line start after reset");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    status_value <= CODE_MAX)
    else $error("status value above saturation limit");
  a_body_done: assert property (@(posedge clk) disable iff (rst)
    body_enabled |-> phase == PH_DONE)
    else $error("body enabled outside finished phase");
  a_value_single: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WS || phase == PH_VALUE) |-> $onehot0(alive))
    else $error("more than one header name matched");

endmodule

// ===== rtl/cgi_header_field_parser.sv =====
// ----------------------------------------------------------------------------
// cgi_header_field_parser: CGI response header byte tagger
// Path: a request is taken into the input register, and its result is then
//   loaded into the output register on a step, which waits while out_stall holds.
// Throughput: one request per cycle unless out_stall holds the output register;
//   the per-byte state update sets the rate. Reset: rst (synchronous) empties
//   both registers and clears parser state; new_response clears parser state ahead of its own byte.
// ----------------------------------------------------------------------------
module cgi_header_field_parser
  import cghp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              new_response,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        kind,
  output logic [7:0]        byte_out,
  output logic [CODE_W-1:0] status_code,
  output logic              status_present
);

  logic         in_full;
  logic [7:0]   in_byte;
  logic         in_new;
  logic         out_adv;
  logic         step;
  cghp_result_t step_result;
  cghp_result_t out_reg;

  assign out_adv  = !out_valid || !out_stall;
  assign step     = in_full && out_adv;
  assign in_stall = in_full && !out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= data_byte;
      in_new  <= new_response;
    end
  end

  cghp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (in_byte),
    .new_response (in_new),
    .result       (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= step_result;
    end
  end

  assign kind           = out_reg.kind;
  assign byte_out       = out_reg.byte_out;
  assign status_code    = out_reg.status_code;
  assign status_present = out_reg.status_present;

endmodule
